// File: sv/hires_artifact_pixel_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// Artifact pixel generator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HIRES_ARTIFACT_PIXEL_GENERATOR_UNIT_DEFINES_SVH
`define HIRES_ARTIFACT_PIXEL_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HAPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hapg assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define HAPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hapg assertion failed");

`endif

// File: sv/hapg_pkg.sv
// ----------------------------------------------------------------------------
// Artifact pixel generator package
// Column descriptor, result record, register indexes, a color table and the hires color functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hapg_pkg;

    localparam int PIXELS = 7;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_ALT_PALETTE  = 1'd0;
    localparam cfg_index_t CFG_DOUBLE_HIRES = 1'd1;

    typedef struct packed {
        logic [6:0] prev;
        logic [7:0] cur;
        logic [6:0] next;
        logic [1:0] col;
        logic       row_end;
    } column_t;

    typedef struct packed {
        logic [PIXELS-1:0][3:0] pixel;
        logic                   double_width;
        logic                   row_end;
    } result_t;

    localparam logic [3:0] DHIRES_COLORS [16] = '{
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    function automatic logic [1:0] hires_level(input logic [2:0] i, input logic j);
        logic [1:0] lvl;
        if (i[1])
        begin
            if (i[0] || i[2])
                lvl = 2'd3;
            else
                lvl = j ? 2'd2 : 2'd1;
        end
        else if (i[0] && i[2])
            lvl = j ? 2'd1 : 2'd2;
        else
            lvl = 2'd0;
        return lvl;
    endfunction

    function automatic logic [3:0] hires_color(input logic set, input logic [1:0] lvl);
        logic [3:0] c;
        case (lvl)
            2'd0:    c = 4'd0;
            2'd1:    c = set ? 4'd6 : 4'd3;
            2'd2:    c = set ? 4'd9 : 4'd12;
            default: c = 4'd15;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/hapg_column.sv
// ----------------------------------------------------------------------------
// Artifact pixel column renderer
// Maps one column's 21-bit window to seven color indices.
// ----------------------------------------------------------------------------
`default_nettype none

module hapg_column
(
    input  wire hapg_pkg::column_t column,
    input  wire logic              alt_palette,
    input  wire logic              double_hires,
    output hapg_pkg::result_t      result
);

    always_comb
    begin
        logic [20:0] w;
        logic        set;
        logic [2:0]  i;
        logic [3:0]  win;
        logic [1:0]  rot;
        logic [7:0]  dbl;
        logic [7:0]  shifted;
        w   = {column.next, column.cur[6:0], column.prev};
        set = alt_palette & column.cur[7];
        result = '0;
        for (int b = 0; b < hapg_pkg::PIXELS; b++)
        begin
            i       = w[b+6 +: 3];
            win     = w[b+6 +: 4];
            // col*7 is -col mod 4
            rot     = 2'd2 + column.col - 2'(b);
            dbl     = {win, win};
            shifted = dbl >> rot;
            if (double_hires)
                result.pixel[b] = hapg_pkg::DHIRES_COLORS[shifted[3:0]];
            else
                result.pixel[b] = hapg_pkg::hires_color(set,
                    hapg_pkg::hires_level(i, 1'(b) ^ column.col[0]));
        end
        result.double_width = ~double_hires;
        result.row_end      = column.row_end;
    end

endmodule

`default_nettype wire

// File: sv/hires_artifact_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Artifact pixel generator
// Scanline bytes in, seven color indices per column out.
// ----------------------------------------------------------------------------
// Bytes of a scanline enter on byte_valid/byte_stall with first_in_row and
// last_in_row marks; each transaction is taken when byte_valid is high and
// byte_stall low. Column results leave on pix_valid/pix_stall.
// A column is emitted once the byte after it arrives; the last byte of a row
// emits two columns (the pending one and itself), a lone first+last byte one.
// Path: a column's result reaches pix_valid through the job register, then the
// output register. Throughput: one byte per cycle while pix_stall is low; a
// row-ending byte that produces two columns holds the input until the job
// register can take a new byte, since the single-column job register feeds
// the output register one column a cycle when not stalled.
// When pix_stall is high the output register holds its result, the job
// register fills behind it and byte_stall rises.
// Reset clears row history, the job and output stages, and sets alt_palette
// to 1 and double_hires to 0. Configuration writes on cfg_valid/cfg_ready are
// always taken and apply to columns emitted afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module hires_artifact_pixel_generator_unit
#(
    parameter int MAX_COLUMNS = 80
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire hapg_pkg::cfg_index_t   cfg_index,
    input  wire logic                   cfg_data,
    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   first_in_row,
    input  wire logic                   last_in_row,
    output logic                        pix_valid,
    input  wire logic                   pix_stall,
    output logic [3:0]                  pixel_0,
    output logic [3:0]                  pixel_1,
    output logic [3:0]                  pixel_2,
    output logic [3:0]                  pixel_3,
    output logic [3:0]                  pixel_4,
    output logic [3:0]                  pixel_5,
    output logic [3:0]                  pixel_6,
    output logic                        double_width,
    output logic                        row_end
);

    localparam int COL_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [COL_W:0] LAST_COL = (COL_W+1)'(MAX_COLUMNS - 1);

    logic                 alt_palette_reg;
    logic                 double_hires_reg;
    logic [7:0]           older_reg, older_next;
    logic [7:0]           newer_reg, newer_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 seen_reg, seen_next;

    logic                 job_valid_reg;
    logic                 job_two_reg;
    hapg_pkg::column_t    job_a_reg, job_b_reg;
    logic                 job_valid_next, job_two_next;
    hapg_pkg::column_t    job_a_next, job_b_next;

    logic                 out_valid_reg;
    hapg_pkg::result_t    out_reg;
    hapg_pkg::result_t    result;

    logic                 accept;
    logic                 advance;
    logic [COL_W:0]       col_inc;

    assign cfg_ready  = 1'b1;
    assign advance    = job_valid_reg && (!out_valid_reg || !pix_stall);
    assign byte_stall = job_valid_reg && !(advance && !job_two_reg);
    assign accept     = byte_valid && !byte_stall;
    assign col_inc    = {1'b0, col_reg} + (COL_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_palette_reg  <= 1'b1;
            double_hires_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hapg_pkg::CFG_ALT_PALETTE:  alt_palette_reg  <= cfg_data;
                hapg_pkg::CFG_DOUBLE_HIRES: double_hires_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        logic last_eff;
        older_next     = older_reg;
        newer_next     = newer_reg;
        col_next       = col_reg;
        seen_next      = seen_reg;
        job_valid_next = 1'b0;
        job_two_next   = 1'b0;
        job_a_next     = '0;
        job_b_next     = '0;
        last_eff       = last_in_row || (col_inc >= LAST_COL);
        if (first_in_row || !seen_reg)
        begin
            older_next = '0;
            col_next   = '0;
            if (last_in_row)
            begin
                job_valid_next     = 1'b1;
                job_a_next.cur     = data_byte;
                job_a_next.row_end = 1'b1;
                newer_next         = '0;
                seen_next          = 1'b0;
            end
            else
            begin
                newer_next = data_byte;
                seen_next  = 1'b1;
            end
        end
        else
        begin
            job_valid_next  = 1'b1;
            job_a_next.prev = older_reg[6:0];
            job_a_next.cur  = newer_reg;
            job_a_next.next = data_byte[6:0];
            job_a_next.col  = 2'(col_reg);
            if (last_eff)
            begin
                job_two_next       = 1'b1;
                job_b_next.prev    = newer_reg[6:0];
                job_b_next.cur     = data_byte;
                job_b_next.col     = 2'(col_inc);
                job_b_next.row_end = 1'b1;
                older_next         = '0;
                newer_next         = '0;
                col_next           = '0;
                seen_next          = 1'b0;
            end
            else
            begin
                older_next = newer_reg;
                newer_next = data_byte;
                col_next   = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            col_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else if (accept)
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            col_reg   <= col_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_two_reg   <= 1'b0;
        end
        else if (advance && job_two_reg)
        begin
            job_two_reg <= 1'b0;
        end
        else if (accept)
        begin
            job_valid_reg <= job_valid_next;
            job_two_reg   <= job_two_next;
        end
        else if (advance)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && job_two_reg)
        begin
            job_a_reg <= job_b_reg;
        end
        else if (accept)
        begin
            job_a_reg <= job_a_next;
            job_b_reg <= job_b_next;
        end
    end

    hapg_column u_column
    (
        .column       (job_a_reg),
        .alt_palette  (alt_palette_reg),
        .double_hires (double_hires_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!pix_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign pix_valid    = out_valid_reg;
    assign pixel_0      = out_reg.pixel[0];
    assign pixel_1      = out_reg.pixel[1];
    assign pixel_2      = out_reg.pixel[2];
    assign pixel_3      = out_reg.pixel[3];
    assign pixel_4      = out_reg.pixel[4];
    assign pixel_5      = out_reg.pixel[5];
    assign pixel_6      = out_reg.pixel[6];
    assign double_width = out_reg.double_width;
    assign row_end      = out_reg.row_end;

endmodule

`default_nettype wire

// File: sv/hapg_checker.sv
// ----------------------------------------------------------------------------
// Artifact pixel generator port checker
// Watches the top level's ports for output and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hires_artifact_pixel_generator_unit_defines.svh"

module hapg_checker
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 byte_valid,
    input wire logic                 byte_stall,
    input wire logic                 pix_valid,
    input wire logic                 pix_stall,
    input wire logic [3:0]           pixel_0,
    input wire logic [3:0]           pixel_1,
    input wire logic [3:0]           pixel_2,
    input wire logic [3:0]           pixel_3,
    input wire logic [3:0]           pixel_4,
    input wire logic [3:0]           pixel_5,
    input wire logic [3:0]           pixel_6,
    input wire logic                 double_width,
    input wire logic                 row_end
);

    logic        byte_take;
    logic [29:0] pix_bus;

    assign byte_take = byte_valid && !byte_stall;
    assign pix_bus   = {pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0,
                        double_width, row_end};

    // a byte reaches pix_valid through the job register, then the output register
    `HAPG_ASSERT_NEXT(a_out_held, pix_valid && pix_stall, pix_valid)
    `HAPG_ASSERT_NEXT(a_out_stable, pix_valid && pix_stall, $stable(pix_bus))
    `HAPG_ASSERT_NEXT(a_stall_drains, byte_stall && !pix_valid, pix_valid)
    `HAPG_ASSERT_NOW(a_no_spurious, !$past(byte_take, 2) && !$past(pix_valid), !pix_valid)

endmodule

bind hires_artifact_pixel_generator_unit hapg_checker u_hapg_checker (.*);

`default_nettype wire

// File: dv/hapg_column_checker.sv
// ----------------------------------------------------------------------------
// Artifact pixel generator column checker
// Watches the config, byte and pixel channels, predicts each column's seven
// color indices from the accepted bytes and register writes, and compares
// every accepted pixel transaction in order against the predicted columns.
// ----------------------------------------------------------------------------
module hapg_column_checker
#(
    parameter int MAX_COLUMNS = 80
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  hapg_pkg::cfg_index_t cfg_index,
    input  logic                 cfg_data,
    input  logic                 byte_valid,
    input  logic                 byte_stall,
    input  logic [7:0]           data_byte,
    input  logic                 first_in_row,
    input  logic                 last_in_row,
    input  logic                 pix_valid,
    input  logic                 pix_stall,
    input  logic [3:0]           pixel_0,
    input  logic [3:0]           pixel_1,
    input  logic [3:0]           pixel_2,
    input  logic [3:0]           pixel_3,
    input  logic [3:0]           pixel_4,
    input  logic [3:0]           pixel_5,
    input  logic [3:0]           pixel_6,
    input  logic                 double_width,
    input  logic                 row_end,
    output int                   mismatches,
    output int                   outstanding
);

    localparam logic [3:0] BLACK  = 4'd0;
    localparam logic [3:0] PURPLE = 4'd3;
    localparam logic [3:0] BLUE   = 4'd6;
    localparam logic [3:0] ORANGE = 4'd9;
    localparam logic [3:0] GREEN  = 4'd12;
    localparam logic [3:0] WHITE  = 4'd15;

    typedef struct packed {
        logic [6:0][3:0] pix;
        logic            double_width;
        logic            row_end;
    } column_colors_t;

    logic           alt_palette;
    logic           double_hires;
    logic [7:0]     prior_byte;
    logic [7:0]     pending_byte;
    logic [6:0]     pending_col;
    logic           row_open;
    column_colors_t expected_columns[$];

    initial mismatches = 0;

    function automatic column_colors_t render_column(input logic [7:0] prev,
                                                     input logic [7:0] cur,
                                                     input logic [7:0] next,
                                                     input logic [6:0] col,
                                                     input logic       last);
        column_colors_t c;
        logic [20:0]    w;
        logic [2:0]     nbhd;
        logic [3:0]     win;
        logic [7:0]     twice;
        logic [3:0]     idx;
        logic [1:0]     rot;
        logic           odd;
        logic [3:0]     hue_a;
        logic [3:0]     hue_b;
        w     = {next[6:0], cur[6:0], prev[6:0]};
        hue_a = (alt_palette && cur[7]) ? BLUE : PURPLE;
        hue_b = (alt_palette && cur[7]) ? ORANGE : GREEN;
        for (int b = 0; b < 7; b++)
        begin
            if (double_hires)
            begin
                win   = w[b+6 +: 4];
                rot   = 2'(2 - (int'(col) * 7 + b));
                twice = {win, win};
                idx   = 4'(twice >> rot);
                c.pix[b] = {idx[1:0], idx[3:2]};
            end
            else
            begin
                nbhd = w[b+6 +: 3];
                odd  = 1'(b) ^ col[0];
                if (nbhd[1])
                    c.pix[b] = (nbhd[0] || nbhd[2]) ? WHITE : (odd ? hue_b : hue_a);
                else if (nbhd[0] && nbhd[2])
                    c.pix[b] = odd ? hue_a : hue_b;
                else
                    c.pix[b] = BLACK;
            end
        end
        c.double_width = ~double_hires;
        c.row_end      = last;
        return c;
    endfunction

    task automatic report(input string what, input int expected_val, input int got_val);
        $display("ERROR at %0t: %s: expected %0d, got %0d", $realtime, what,
                 expected_val, got_val);
        mismatches++;
    endtask

    task automatic check_column();
        column_colors_t  want;
        logic [6:0][3:0] seen;
        seen = {pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
        if (expected_columns.size() == 0)
        begin
            report("pixel transaction with no column pending", 0, 1);
            return;
        end
        want = expected_columns.pop_front();
        for (int k = 0; k < 7; k++)
            if (seen[k] !== want.pix[k])
                report($sformatf("pixel_%0d", k), want.pix[k], seen[k]);
        if (double_width !== want.double_width)
            report("double_width", want.double_width, double_width);
        if (row_end !== want.row_end)
            report("row_end", want.row_end, row_end);
    endtask

    task automatic predict_byte(input logic [7:0] d, input logic first, input logic last);
        logic closes;
        if (first || !row_open)
        begin
            if (last)
            begin
                expected_columns.push_back(render_column(8'h00, d, 8'h00, 7'd0, 1'b1));
                row_open = 1'b0;
            end
            else
                row_open = 1'b1;
            prior_byte   = 8'h00;
            pending_byte = last ? 8'h00 : d;
            pending_col  = 7'd0;
            return;
        end
        closes = last || (int'(pending_col) + 1 >= MAX_COLUMNS - 1);
        expected_columns.push_back(render_column(prior_byte, pending_byte, d,
                                                 pending_col, 1'b0));
        if (closes)
        begin
            expected_columns.push_back(render_column(pending_byte, d, 8'h00,
                                                     pending_col + 7'd1, 1'b1));
            prior_byte   = 8'h00;
            pending_byte = 8'h00;
            pending_col  = 7'd0;
            row_open     = 1'b0;
        end
        else
        begin
            prior_byte   = pending_byte;
            pending_byte = d;
            pending_col  = pending_col + 7'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_palette  = 1'b1;
            double_hires = 1'b0;
            prior_byte   = 8'h00;
            pending_byte = 8'h00;
            pending_col  = 7'd0;
            row_open     = 1'b0;
            expected_columns.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hapg_pkg::CFG_ALT_PALETTE:  alt_palette  = cfg_data;
                    hapg_pkg::CFG_DOUBLE_HIRES: double_hires = cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                check_column();
            if (byte_valid && !byte_stall)
                predict_byte(data_byte, first_in_row, last_in_row);
            outstanding <= expected_columns.size();
        end
    end

endmodule

// File: dv/hires_artifact_pixel_generator_unit_test.sv
// ----------------------------------------------------------------------------
// Artifact pixel generator testbench
// Drives scanline bytes in bursts through the generator under several palette
// and double-hires settings: a directed set of row corner cases, then random
// well-formed, broken and overlong rows, with a randomly stalling receiver.
// A column checker beside the block predicts and compares every column.
// ----------------------------------------------------------------------------
module hires_artifact_pixel_generator_unit_test;

    localparam int MAX_COLUMNS = 80;
    localparam int HOLD_CYCLES = 150;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum {ROW_NOISE, ROW_OVERLONG, ROW_UNTERMINATED, ROW_HEADLESS, ROW_NORMAL}
        row_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    hapg_pkg::cfg_index_t cfg_index;
    logic                 cfg_data;
    logic                 byte_valid;
    logic                 byte_stall;
    logic [7:0]           data_byte;
    logic                 first_in_row;
    logic                 last_in_row;
    logic                 pix_valid;
    logic                 pix_stall;
    logic [3:0]           pixel_0;
    logic [3:0]           pixel_1;
    logic [3:0]           pixel_2;
    logic [3:0]           pixel_3;
    logic [3:0]           pixel_4;
    logic [3:0]           pixel_5;
    logic [3:0]           pixel_6;
    logic                 double_width;
    logic                 row_end;
    int                   mismatches;
    int                   outstanding;

    int          burst_left;
    int          bytes_sent;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    int          mode_left;
    stall_mode_t stall_mode;

    hires_artifact_pixel_generator_unit #(.MAX_COLUMNS(MAX_COLUMNS)) i_dut (.*);

    hapg_column_checker #(.MAX_COLUMNS(MAX_COLUMNS)) i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure; long hold-offs on request
    initial
    begin
        pix_stall <= 1'b0;
        holds_served = 0;
        hold_left = 0;
        mode_left = 0;
        stall_mode = STALL_NONE;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pix_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:  pix_stall <= 1'b0;
                    STALL_LIGHT: pix_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: pix_stall <= ($urandom_range(0, 3) != 0);
                    default:     pix_stall <= ~pix_stall;
                endcase
            end
        end
    end

    function automatic logic [7:0] random_byte();
        logic [7:0] d;
        case ($urandom_range(0, 7))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            2:       d = 8'h7F;
            3:       d = $urandom_range(0, 1) ? 8'hD5 : 8'hAA;
            default: d = 8'($urandom);
        endcase
        return d;
    endfunction

    function automatic row_kind_t pick_row_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return ROW_NOISE;
        if (r < 8)
            return ROW_OVERLONG;
        if (r < 16)
            return ROW_UNTERMINATED;
        if (r < 22)
            return ROW_HEADLESS;
        return ROW_NORMAL;
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        byte_valid   <= 1'b1;
        data_byte    <= d;
        first_in_row <= first;
        last_in_row  <= last;
        do
            @(posedge clk);
        while (byte_stall);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_row(input int len, input logic head, input logic tail);
        for (int i = 0; i < len; i++)
            send_byte(random_byte(), head && (i == 0), tail && (i == len - 1));
    endtask

    task automatic write_register(input hapg_pkg::cfg_index_t idx, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int quota);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < quota)
        begin
            case (pick_row_kind())
                ROW_NOISE:
                    send_byte(random_byte(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                ROW_OVERLONG:
                    send_row($urandom_range(MAX_COLUMNS, MAX_COLUMNS + 6), 1'b1, 1'b0);
                ROW_UNTERMINATED:
                    send_row($urandom_range(1, 6), 1'b1, 1'b0);
                ROW_HEADLESS:
                    send_row($urandom_range(1, 6), 1'b0, 1'b1);
                default:
                    send_row(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                         : $urandom_range(1, 8),
                             1'b1, 1'b1);
            endcase
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= hapg_pkg::CFG_ALT_PALETTE;
        cfg_data     <= 1'b0;
        byte_valid   <= 1'b0;
        data_byte    <= 8'h00;
        first_in_row <= 1'b0;
        last_in_row  <= 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        hold_requests = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(hapg_pkg::CFG_ALT_PALETTE, 1'b1);
        write_register(hapg_pkg::CFG_DOUBLE_HIRES, 1'b0);

        // single-column rows, with and without a first mark
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        // plain row across the extremes
        send_byte(8'h7F, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // row opened without a first mark
        send_byte(8'h2A, 1'b0, 1'b0);
        send_byte(8'hD5, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // restart while a row is open
        send_byte(8'h33, 1'b1, 1'b0);
        send_byte(8'hC4, 1'b0, 1'b0);
        send_byte(8'h11, 1'b1, 1'b0);
        send_byte(8'h40, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
        // two-column row, then first+last over an open row
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h0F, 1'b1, 1'b0);
        send_byte(8'hF0, 1'b1, 1'b1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            write_register(hapg_pkg::CFG_ALT_PALETTE, ~1'(p));
            write_register(hapg_pkg::CFG_DOUBLE_HIRES, 1'(p >> 1));
            if (p == 2 || p == 5)
                hold_requests <= hold_requests + 1;
            if (p == 3)
                send_row(MAX_COLUMNS + 2, 1'b1, 1'b0);
            run_phase(80);
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/hapg_pkg.sv
sv/hapg_column.sv
sv/hires_artifact_pixel_generator_unit.sv
sv/hapg_checker.sv
dv/hapg_column_checker.sv
dv/hires_artifact_pixel_generator_unit_test.sv
